// ===== sv/asin_pkg.sv =====
// Shared types, constants and arithmetic helpers for the arcsine pipeline.
`timescale 1ns / 1ps
`default_nettype none
package asin_pkg;

  localparam int IN_W          = 18;
  localparam int OUT_W         = 18;
  localparam int WORK_BITS     = 32;
  localparam int SUM_W         = 36;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_COEF      = 7;

  // pi/2 in Q1.62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef logic [WORK_BITS-1:0] word_t;
  typedef logic [SUM_W-1:0]     sum_t;

  // Series coefficients for x^3 .. x^15, rounded to Q0.32
  function automatic word_t coef(input logic [2:0] idx);
    word_t c;
    case (idx)
      3'd0:    c = 32'd715827883;  // 1/6
      3'd1:    c = 32'd322122547;  // 3/40
      3'd2:    c = 32'd191739611;  // 5/112
      3'd3:    c = 32'd130489458;  // 35/1152
      3'd4:    c = 32'd96087692;   // 63/2816
      3'd5:    c = 32'd74529556;   // 231/13312
      3'd6:    c = 32'd59978547;   // 429/30720
      default: c = '0;
    endcase
    return c;
  endfunction

  // Q0.32 times Q0.32, rounded half up back to Q0.32
  function automatic word_t mul_q32(input word_t a, input word_t b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b) + (64'd1 << (WORK_BITS - 1));
    return prod[63:32];
  endfunction

endpackage
`default_nettype wire

// ===== sv/asin_in_if.sv =====
// Input stream channel: valid/ready handshake carrying one sine value.
`timescale 1ns / 1ps
`default_nettype none
interface asin_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [asin_pkg::IN_W-1:0]    x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface
`default_nettype wire

// ===== sv/asin_out_if.sv =====
// Result stream channel: valid/ready handshake carrying one angle.
`timescale 1ns / 1ps
`default_nettype none
interface asin_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [asin_pkg::OUT_W-1:0]   angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface
`default_nettype wire

// ===== sv/arcsin_taylor_polynomial_top.sv =====
// Pipelined arcsine by a degree-15 odd Taylor series in signed fixed point.
//
// Usage:
//   in_ch  : sink of sine values x_value (signed, FRAC_BITS fraction bits).
//            A transfer happens on a rising clk edge with valid and ready high.
//   out_ch : source of angle results in the same format, one per input,
//            delivered in input order.
// Path: an input transfer loads stage 0, the item passes through 11 pipeline
//   stages and then the output register, where out_ch.valid rises; when the
//   receiver stalls, full stages hold their item on the way.
// Throughput: one item per cycle unless out_ch.ready stalls the pipe; the
//   chained power multiplications set the depth, at most one per stage.
// Magnitude exactly 1.0 gives +/- round(pi/2), magnitude above 1.0 gives 0.
// Reset (rst_n low, synchronous) empties every stage and the output register.
// Stall: each stage holds while the one after it is full and holding, so
//   bubbles collapse; in_ch.ready drops only when every stage and the output
//   register hold data and out_ch.ready is low. Nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module arcsin_taylor_polynomial_top #(
  parameter int FRAC_BITS = asin_pkg::FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  asin_in_if.sink     in_ch,
  asin_out_if.source  out_ch
);

  localparam int LAST = 10;                              // last series stage
  localparam int SH   = asin_pkg::WORK_BITS - FRAC_BITS; // Q0.32 to output grid

  localparam logic [31:0] ONE_VAL = 32'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_RND =
    (asin_pkg::HALF_PI_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
  localparam logic [asin_pkg::OUT_W-1:0] HALF_PI_OUT = HALF_RND[asin_pkg::OUT_W-1:0];
  localparam asin_pkg::sum_t RND_C = asin_pkg::sum_t'(1) << (SH - 1);

  // Per-item control flags carried alongside the data
  typedef struct packed {
    logic neg;   // input was negative
    logic big;   // magnitude above 1.0
    logic one;   // magnitude exactly 1.0
  } flags_t;

  // Stage 0: sign, magnitude and rescaled Q0.32 operand
  logic                  v_r     [0:LAST];
  flags_t                flg_r   [0:LAST];
  flags_t                flg0_nxt;
  flags_t                flg_nxt [1:LAST];
  asin_pkg::word_t       m0_r, m0_nxt;

  // Series stages: squared operand, odd powers, terms and running sum
  asin_pkg::word_t       sq_r    [1:7];
  asin_pkg::word_t       sq_nxt  [1:7];
  asin_pkg::word_t       pw_r    [1:8];
  asin_pkg::word_t       pw_nxt  [1:8];
  asin_pkg::sum_t        term_r  [1:9];
  asin_pkg::sum_t        term_nxt[1:9];
  asin_pkg::sum_t        sum_r   [1:LAST];
  asin_pkg::sum_t        sum_nxt [1:LAST];

  // Load enables: a stage takes new data when empty or when it drains
  logic                  ld      [0:LAST+1];

  logic                  out_v_r;
  logic [asin_pkg::OUT_W-1:0] angle_r, angle_nxt;

  logic [asin_pkg::IN_W-1:0]  raw;
  logic [asin_pkg::IN_W-1:0]  mag;
  logic [31:0]                mag_ext;
  asin_pkg::sum_t             rnd;
  asin_pkg::sum_t             shifted;
  logic [asin_pkg::OUT_W-1:0] res_mag;
  logic [asin_pkg::OUT_W-1:0] res_sel;

  // Ready chain from the output register back to the input
  always_comb begin
    ld[LAST+1] = !out_v_r || out_ch.ready;
    for (int k = LAST; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_ch.ready  = ld[0];
  assign out_ch.valid = out_v_r;
  assign out_ch.angle = angle_r;

  // Stage 0: fold the sign and classify the magnitude
  always_comb begin
    raw     = in_ch.x_value;
    mag     = raw[asin_pkg::IN_W-1] ? (~raw + 1'b1) : raw;
    mag_ext = 32'(mag);
    flg0_nxt.neg = raw[asin_pkg::IN_W-1];
    flg0_nxt.big = mag_ext > ONE_VAL;
    flg0_nxt.one = mag_ext == ONE_VAL;
    m0_nxt  = mag_ext << SH;
  end

  // Series stages
  always_comb begin
    for (int k = 1; k <= LAST; k++) begin
      flg_nxt[k] = flg_r[k-1];
    end
    // x^2, passed down for the power chain
    sq_nxt[1] = asin_pkg::mul_q32(m0_r, m0_r);
    for (int k = 2; k <= 7; k++) begin
      sq_nxt[k] = sq_r[k-1];
    end
    // stage k holds x^(2k-1)
    pw_nxt[1] = m0_r;
    for (int k = 2; k <= 8; k++) begin
      pw_nxt[k] = asin_pkg::mul_q32(pw_r[k-1], sq_r[k-1]);
    end
    // linear term first, a zero term next, then one coefficient product per stage
    term_nxt[1] = asin_pkg::sum_t'(m0_r);
    term_nxt[2] = '0;
    for (int k = 3; k <= 9; k++) begin
      term_nxt[k] = asin_pkg::sum_t'(asin_pkg::mul_q32(asin_pkg::coef(3'(k - 3)),
                                                       pw_r[k-1]));
    end
    // accumulate the term registered one stage earlier
    sum_nxt[1] = '0;
    for (int k = 2; k <= LAST; k++) begin
      sum_nxt[k] = sum_r[k-1] + term_r[k-1];
    end
  end

  // Output: round to the output grid, pick special cases, apply the sign
  always_comb begin
    rnd     = sum_r[LAST] + RND_C;
    shifted = rnd >> SH;
    res_mag = shifted[asin_pkg::OUT_W-1:0];
    if (flg_r[LAST].big) begin
      res_sel = '0;
    end else if (flg_r[LAST].one) begin
      res_sel = HALF_PI_OUT;
    end else begin
      res_sel = res_mag;
    end
    angle_nxt = flg_r[LAST].neg ? (~res_sel + 1'b1) : res_sel;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) begin
        v_r[k] <= 1'b0;
      end
      out_v_r <= 1'b0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (ld[LAST+1]) begin
        out_v_r <= v_r[LAST];
      end
    end
  end

  // Payload registers: advance with their stage, hold otherwise
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      flg_r[0] <= flg0_nxt;
      m0_r     <= m0_nxt;
    end
    for (int k = 1; k <= LAST; k++) begin
      if (ld[k]) begin
        flg_r[k] <= flg_nxt[k];
        sum_r[k] <= sum_nxt[k];
      end
    end
    for (int k = 1; k <= 7; k++) begin
      if (ld[k]) begin
        sq_r[k] <= sq_nxt[k];
      end
    end
    for (int k = 1; k <= 8; k++) begin
      if (ld[k]) begin
        pw_r[k] <= pw_nxt[k];
      end
    end
    for (int k = 1; k <= 9; k++) begin
      if (ld[k]) begin
        term_r[k] <= term_nxt[k];
      end
    end
    if (ld[LAST+1]) begin
      angle_r <= angle_nxt;
    end
  end

  // Input backpressure only when the first, middle and last stages and the output are full and the output stalls
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v_r[0] && v_r[5] && v_r[LAST] && out_v_r && !out_ch.ready))
    else $error("input blocked while pipeline has room");

  // Reset empties the first, last and output stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !v_r[0] && !v_r[LAST]))
    else $error("pipeline not empty after reset");

  // A full last stage behind a stalled output keeps its sum
  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready && v_r[LAST]) |=> $stable(sum_r[LAST]))
    else $error("last stage changed while stalled");

endmodule
`default_nettype wire
